FILE: hw/rtl/pfdc_pkg.sv
// Package for the per-flow DRR/CoDel scheduler: sizes, status codes,
// register indexes and sequencer states. Used by every module of the block.
package pfdc_pkg;
  localparam int unsigned NumFlows  = 64;
  localparam int unsigned FlowDepth = 16;
  localparam int unsigned FlowW     = $clog2(NumFlows);
  localparam int unsigned SlotW     = $clog2(FlowDepth);
  localparam int unsigned FillW     = $clog2(FlowDepth + 1);
  localparam int unsigned AddrW     = FlowW + SlotW;
  localparam int unsigned ListW     = $clog2(NumFlows + 1);
  localparam int unsigned BytesW    = 26;
  localparam int unsigned CreditW   = 18;
  localparam logic [10:0] DropMax   = 11'd2047;
  localparam logic [15:0] CountMax  = 16'hFFFF;

  localparam logic [1:0] StEnq    = 2'd0;
  localparam logic [1:0] StFull   = 2'd1;
  localparam logic [1:0] StSent   = 2'd2;
  localparam logic [1:0] StNone   = 2'd3;

  localparam logic [1:0] RegTarget   = 2'd0;
  localparam logic [1:0] RegInterval = 2'd1;
  localparam logic [1:0] RegQuantum  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_ENQ_RD, S_ENQ_WR, S_LIST_RD, S_FLOW_RD, S_PICK,
    S_PKT_RD, S_JUDGE, S_DECIDE, S_SQRT, S_DIV, S_LAW, S_WB, S_OUT
  } state_e;

  typedef enum logic [1:0] {L_IDLE, L_SQRT, L_DIV, L_DONE} law_state_e;

  typedef struct packed {
    logic [SlotW-1:0]   head;
    logic [FillW-1:0]   fill;
    logic [CreditW-1:0] credit;
    logic               active;
    logic [31:0]        above;
    logic [31:0]        next_drop;
    logic [15:0]        count;
    logic               dropping;
  } flow_t;

  typedef struct packed {
    logic        start;
    logic [15:0] radicand;
    logic [15:0] dividend;
  } law_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } law_rsp_t;
endpackage

FILE: hw/rtl/pfdc_law_unit.sv
// Control-law step unit: floor(interval / max(1, isqrt(count))), computed
// bit-serially. Depends on pfdc_pkg.
module pfdc_law_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfdc_pkg::law_req_t req_i,
  output pfdc_pkg::law_rsp_t rsp_o
);
  import pfdc_pkg::*;

  law_state_e  st_q, st_d;
  logic [15:0] v_q, r_q, b_q, dvd_q, quo_q, den_q, rem_q;
  logic [4:0]  n_q;

  logic [16:0] rb;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  assign rb      = {1'b0, r_q} + {1'b0, b_q};
  assign rem_sh  = {rem_q, dvd_q[15]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= L_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      L_IDLE: if (req_i.start) st_d = L_SQRT;
      L_SQRT: if (b_q == 16'd0) st_d = L_DIV;
      L_DIV:  if (n_q == 5'd0) st_d = L_DONE;
      L_DONE: st_d = L_IDLE;
      default: st_d = L_IDLE;
    endcase
    rsp_o.done = (st_q == L_DONE);
    rsp_o.quot = quo_q;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      L_IDLE: begin
        v_q <= req_i.radicand; r_q <= '0; b_q <= 16'h4000;
        dvd_q <= req_i.dividend; rem_q <= '0; quo_q <= '0; n_q <= 5'd16;
      end
      L_SQRT: begin
        if (b_q != 16'd0) begin
          if ({1'b0, v_q} >= rb) begin
            v_q <= v_q - rb[15:0];
            r_q <= (r_q >> 1) + b_q;
          end else begin
            r_q <= r_q >> 1;
          end
          b_q <= b_q >> 2;
        end else begin
          den_q <= (r_q == 16'd0) ? 16'd1 : r_q;
        end
      end
      L_DIV: begin
        if (n_q != 5'd0) begin
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= rem_sub[15:0];
            quo_q <= {quo_q[14:0], 1'b1};
          end else begin
            rem_q <= rem_sh[15:0];
            quo_q <= {quo_q[14:0], 1'b0};
          end
          dvd_q <= {dvd_q[14:0], 1'b0};
          n_q   <= n_q - 5'd1;
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: hw/rtl/per_flow_drr_codel_scheduler.sv
// Top level of the per-flow DRR/CoDel scheduler: request channel, result
// register, APB registers and the sequencer. Depends on pfdc_pkg, pfdc_law_unit.
//
// One request is handled at a time by a sequencer working on three
// synchronous memories (packet store, per-flow state, round-robin list),
// each read through a registered output and written back read-modify-write.
// An enqueue reads the flow record, then writes the packet and the record.
// A dequeue either finds the list empty or sends a packet, passing over
// flows in the list walk; CoDel may examine further packets of the flow,
// and each drop that updates the next drop time runs the shared bit-serial
// square-root and divide unit.
// A finished result moves into an output register that holds it while the
// receiver stalls; the next request is taken as soon as the sequencer is
// idle, and a new result waits in the sequencer until that register frees.
// There is no clearing pass: per-flow state uses valid bits cleared at reset.
module per_flow_drr_codel_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        action_i,
  input  logic [5:0]  flow_id_i,
  input  logic [15:0] packet_length_i,
  input  logic [31:0] packet_tag_i,
  input  logic [31:0] now_time_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  out_flow_o,
  output logic [15:0] out_length_o,
  output logic [31:0] out_tag_o,
  output logic [10:0] dropped_now_o,
  output logic [25:0] backlog_bytes_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pfdc_pkg::*;

  // Configuration registers.
  logic [15:0] target_q, interval_q, quantum_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 16'd5; interval_q <= 16'd100; quantum_q <= 16'd1500;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        RegTarget:   target_q   <= pwdata[15:0];
        RegInterval: interval_q <= pwdata[15:0];
        RegQuantum:  quantum_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      RegTarget:   prdata = {16'd0, target_q};
      RegInterval: prdata = {16'd0, interval_q};
      RegQuantum:  prdata = {16'd0, quantum_q};
      default:     prdata = '0;
    endcase
  end

  // Memories: packet store, per-flow record, round-robin list.
  logic [79:0]   pkt_mem [NumFlows*FlowDepth];
  flow_t         flow_mem [NumFlows];
  logic [FlowW-1:0] list_mem [NumFlows];
  logic [NumFlows-1:0] flow_vld_q;

  logic [AddrW-1:0] pkt_ra, pkt_wa;
  logic             pkt_we;
  logic [79:0]      pkt_wd, pkt_rd_q;
  logic [FlowW-1:0] flow_ra, flow_wa;
  logic             flow_we;
  flow_t            flow_wd, flow_raw_q, flow_rd;
  logic             flow_rvld_q;
  logic [FlowW-1:0] list_ra, list_wa, list_wd, list_rd_q;
  logic             list_we;

  always_ff @(posedge clk_i) begin
    if (pkt_we) pkt_mem[pkt_wa] <= pkt_wd;
    pkt_rd_q <= pkt_mem[pkt_ra];
    if (flow_we) flow_mem[flow_wa] <= flow_wd;
    flow_raw_q <= flow_mem[flow_ra];
    if (list_we) list_mem[list_wa] <= list_wd;
    list_rd_q <= list_mem[list_ra];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_vld_q <= '0; flow_rvld_q <= 1'b0;
    end else begin
      flow_rvld_q <= flow_vld_q[flow_ra];
      if (flow_we) flow_vld_q[flow_wa] <= 1'b1;
    end
  end
  assign flow_rd = flow_rvld_q ? flow_raw_q : '0;

  // Sequencer registers.
  state_e st_q, st_d;
  logic [ListW-1:0] lfill_q, lfill_d;
  logic [FlowW-1:0] lhead_q, lhead_d;
  logic [BytesW-1:0] tot_q, tot_d;
  logic [FlowW-1:0] fid_q, fid_d;
  logic [15:0] len_q;
  logic [31:0] tag_q, now_q;
  flow_t       fl_q, fl_d;
  logic        pv_q, pv_d, ok_q, ok_d;
  logic [1:0]  mode_q, mode_d;  // 0 first pop, 1 dropping loop, 2 entry pop
  logic [15:0] plen_q, plen_d;
  logic [31:0] ptag_q, ptag_d, lawt_q, lawt_d;
  logic [10:0] drops_q, drops_d;
  logic        ovld_q, ovld_d;
  logic [1:0]  ost_q, ost_d;
  logic [5:0]  oflow_q, oflow_d;
  logic [15:0] olen_q, olen_d;
  logic [31:0] otag_q, otag_d;
  logic [10:0] odrop_q, odrop_d;
  law_req_t    law_req;
  law_rsp_t    law_rsp;

  // Output register, loaded when the sequencer finishes a request.
  logic              out_load;
  logic [1:0]        res_status_q;
  logic [5:0]        res_flow_q;
  logic [15:0]       res_len_q;
  logic [31:0]       res_tag_q;
  logic [10:0]       res_drop_q;
  logic [BytesW-1:0] res_bytes_q;

  pfdc_law_unit u_law (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(law_req), .rsp_o(law_rsp));

  logic accept;
  assign stall_o  = (st_q != S_IDLE);
  assign accept   = valid_i && !stall_o;
  assign out_load = (st_q == S_OUT) && (!ovld_q || !stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; lfill_q <= '0; lhead_q <= '0; tot_q <= '0; ovld_q <= 1'b0;
    end else begin
      st_q <= st_d; lfill_q <= lfill_d; lhead_q <= lhead_d; tot_q <= tot_d;
      ovld_q <= ovld_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (accept) begin
      len_q <= packet_length_i;
      tag_q <= packet_tag_i; now_q <= now_time_i;
    end
    fid_q <= fid_d; fl_q <= fl_d; pv_q <= pv_d; ok_q <= ok_d; mode_q <= mode_d;
    plen_q <= plen_d; ptag_q <= ptag_d; lawt_q <= lawt_d; drops_q <= drops_d;
    ost_q <= ost_d; oflow_q <= oflow_d; olen_q <= olen_d; otag_q <= otag_d;
    odrop_q <= odrop_d;
    if (out_load) begin
      res_status_q <= ost_q; res_flow_q <= oflow_q; res_len_q <= olen_q;
      res_tag_q <= otag_q; res_drop_q <= odrop_q; res_bytes_q <= tot_q;
    end
  end

  logic [FlowW-1:0]  tail;
  logic [BytesW-1:0] tot_after;
  logic [31:0]       sojourn, pkt_arr;
  logic [31:0]       since;
  logic [34:0]       window;
  logic              no_more;
  assign tail      = lhead_q + lfill_q[FlowW-1:0];
  assign pkt_arr   = pkt_rd_q[79:48];
  assign tot_after = tot_q - {{(BytesW-16){1'b0}}, pkt_rd_q[15:0]};
  assign sojourn   = now_q - pkt_arr;
  assign since     = now_q - fl_q.next_drop;
  assign window    = {interval_q, 3'b000} + 35'd0;
  assign no_more   = (fl_q.fill == '0);

  always_comb begin
    st_d = st_q; lfill_d = lfill_q; lhead_d = lhead_q; tot_d = tot_q;
    fid_d = fid_q; fl_d = fl_q; pv_d = pv_q; ok_d = ok_q; mode_d = mode_q;
    plen_d = plen_q; ptag_d = ptag_q; lawt_d = lawt_q; drops_d = drops_q;
    ovld_d = ovld_q && stall_i; ost_d = ost_q; oflow_d = oflow_q;
    olen_d = olen_q; otag_d = otag_q; odrop_d = odrop_q;
    pkt_ra = '0; pkt_wa = '0; pkt_we = 1'b0; pkt_wd = '0;
    flow_ra = fid_q; flow_wa = fid_q; flow_we = 1'b0; flow_wd = fl_q;
    list_ra = lhead_q; list_wa = tail; list_we = 1'b0; list_wd = fid_q;
    law_req.start = 1'b0; law_req.radicand = fl_q.count; law_req.dividend = interval_q;
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          fid_d = flow_id_i; flow_ra = flow_id_i; drops_d = '0;
          st_d = action_i ? S_PICK : S_ENQ_RD;
          list_ra = lhead_q;
        end
      end
      S_ENQ_RD: begin
        fl_d = flow_rd; st_d = S_ENQ_WR;
      end
      S_ENQ_WR: begin
        ost_d = StFull; oflow_d = '0; olen_d = '0; otag_d = '0; odrop_d = '0;
        if (fl_q.fill < FillW'(FlowDepth)) begin
          ost_d = StEnq;
          pkt_we = 1'b1;
          pkt_wa = {fid_q, SlotW'(fl_q.head + fl_q.fill[SlotW-1:0])};
          pkt_wd = {now_q, tag_q, len_q};
          flow_wd.fill = fl_q.fill + FillW'(1);
          tot_d = tot_q + {{(BytesW-16){1'b0}}, len_q};
          if (!fl_q.active) begin
            flow_wd.active = 1'b1; flow_wd.credit = '0;
            if (lfill_q < ListW'(NumFlows)) begin
              list_we = 1'b1; lfill_d = lfill_q + ListW'(1);
            end
          end
          flow_we = 1'b1;
        end
        st_d = S_OUT;
      end
      S_LIST_RD: begin
        list_ra = lhead_q; st_d = S_PICK;
      end
      S_PICK: begin
        // list_rd_q holds the head entry now; fetch its flow record.
        if (lfill_q == '0) begin
          ost_d = StNone; oflow_d = '0; olen_d = '0; otag_d = '0; odrop_d = drops_q;
          st_d = S_OUT;
        end else begin
          fid_d = list_rd_q; flow_ra = list_rd_q; st_d = S_FLOW_RD;
        end
      end
      S_FLOW_RD: begin
        fl_d = flow_rd;
        if (flow_rd.fill == '0 || flow_rd.credit[CreditW-1]) begin
          fl_d.credit = '0; fl_d.active = 1'b0;
          lhead_d = lhead_q + FlowW'(1); lfill_d = lfill_q - ListW'(1);
          if (flow_rd.fill != '0) begin
            // Leaving the list clears the credit, so a requeued flow
            // restarts with exactly one quantum.
            fl_d.active = 1'b1;
            fl_d.credit = {{(CreditW-16){1'b0}}, quantum_q};
            list_we = 1'b1; list_wa = lhead_q + lfill_q[FlowW-1:0]; list_wd = fid_q;
            lfill_d = lfill_q;
          end
          flow_we = 1'b1; flow_wd = fl_d;
          st_d = S_LIST_RD;
        end else begin
          mode_d = 2'd0; st_d = S_PKT_RD;
        end
      end
      S_PKT_RD: begin
        if (no_more) begin
          pv_d = 1'b0; ok_d = 1'b0; fl_d.above = '0; st_d = S_DECIDE;
        end else begin
          pkt_ra = {fid_q, fl_q.head}; st_d = S_JUDGE;
        end
      end
      S_JUDGE: begin
        pv_d = 1'b1; ok_d = 1'b0;
        plen_d = pkt_rd_q[15:0]; ptag_d = pkt_rd_q[47:16];
        fl_d.head = fl_q.head + SlotW'(1);
        fl_d.fill = fl_q.fill - FillW'(1);
        tot_d = tot_after;
        if (sojourn < {16'd0, target_q} || tot_after < {10'd0, quantum_q}
            || fl_d.fill == '0) begin
          fl_d.above = '0;
        end else if (fl_q.above == '0) begin
          fl_d.above = now_q + {16'd0, interval_q};
        end else if (now_q >= fl_q.above) begin
          ok_d = 1'b1;
        end
        st_d = S_DECIDE;
      end
      S_DECIDE: begin
        st_d = S_WB;
        if (mode_q == 2'd0) begin
          if (fl_q.dropping) begin
            if (!ok_q) fl_d.dropping = 1'b0;
            mode_d = 2'd1;
            if (now_q >= fl_q.next_drop && (ok_q || !fl_q.dropping)
                && fl_d.dropping) begin
              if (drops_q != DropMax) drops_d = drops_q + 11'd1;
              st_d = S_PKT_RD;
            end
          end else if (ok_q) begin
            if (drops_q != DropMax) drops_d = drops_q + 11'd1;
            mode_d = 2'd2; st_d = S_PKT_RD;
          end
        end else begin
          if (!pv_q) begin
            fl_d.above = '0; fl_d.credit = '0; fl_d.active = 1'b0;
            if (lfill_q != '0) begin
              lhead_d = lhead_q + FlowW'(1); lfill_d = lfill_q - ListW'(1);
            end
          end
          if (mode_q == 2'd2) begin
            fl_d.dropping = 1'b1;
            if (fl_q.count > 16'd2 && {3'b000, since} < window)
              fl_d.count = fl_q.count - 16'd2;
            else
              fl_d.count = 16'd1;
            lawt_d = now_q; st_d = S_SQRT;
          end else if (!ok_q) begin
            fl_d.dropping = 1'b0;
          end else begin
            if (fl_q.count != CountMax) fl_d.count = fl_q.count + 16'd1;
            lawt_d = fl_q.next_drop; st_d = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        law_req.start = 1'b1; st_d = S_DIV;
      end
      S_DIV: begin
        if (law_rsp.done) begin
          fl_d.next_drop = lawt_q + {16'd0, law_rsp.quot};
          st_d = S_LAW;
        end
      end
      S_LAW: begin
        // Dropping loop continues while due.
        if (mode_q == 2'd1 && now_q >= fl_q.next_drop) begin
          if (drops_q != DropMax) drops_d = drops_q + 11'd1;
          st_d = S_PKT_RD;
        end else begin
          st_d = S_WB;
        end
      end
      S_WB: begin
        flow_we = 1'b1; flow_wd = fl_q;
        if (pv_q) begin
          flow_wd.credit = fl_q.credit - {{(CreditW-16){1'b0}}, plen_q};
          ost_d = StSent; oflow_d = fid_q; olen_d = plen_q; otag_d = ptag_q;
          odrop_d = drops_q; st_d = S_OUT;
        end else begin
          st_d = S_LIST_RD;
        end
      end
      S_OUT: begin
        // Wait here while the previous result is still held by the receiver.
        if (!ovld_q || !stall_i) begin
          ovld_d = 1'b1; st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign valid_o = ovld_q;
  assign status_o = res_status_q;
  assign out_flow_o = res_flow_q;
  assign out_length_o = res_len_q;
  assign out_tag_o = res_tag_q;
  assign dropped_now_o = res_drop_q;
  assign backlog_bytes_o = res_bytes_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !accept) else $error("request taken while busy");
  a_list_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfill_q <= ListW'(NumFlows)) else $error("list overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o) else $error("result lost");
endmodule
